// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the date compare design
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define GDNC_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("gdnc assertion failed");

// next-cycle implication, checked out of reset
`define GDNC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("gdnc assertion failed");

`endif

// ===== design/gdnc_pkg.sv =====
// ----------------------------------------------------------------------------
// gdnc_pkg
// types, constants and tables for the gregorian day number compare core
// ----------------------------------------------------------------------------
package gdnc_pkg;

    localparam int unsigned DAY_W       = 5;
    localparam int unsigned MONTH_W     = 4;
    localparam int unsigned YEAR_W      = 14;
    localparam int unsigned SECOND_W    = 17;
    localparam int unsigned YY_W        = 15;
    localparam int unsigned MM_W        = 4;
    localparam int unsigned SPAN_W      = 9;
    localparam int unsigned JDN_W       = 23;
    localparam int unsigned DIFF_W      = 22;
    localparam int unsigned WEEKDAY_W   = 3;
    localparam int unsigned Q100_W      = 9;
    localparam int unsigned Q7_W        = 21;
    localparam int unsigned RECIP100_W  = 13;
    localparam int unsigned RECIP7_W    = 24;

    localparam int unsigned IN_W        = 80;
    localparam int unsigned OUT_FIELDS_W = 75;
    localparam int unsigned OUT_W       = 80;

    localparam logic [SECOND_W-1:0] MAX_SECOND  = 17'd86399;
    localparam logic [YEAR_W-1:0]   MAX_YEAR    = 14'd9999;
    localparam logic [YY_W-1:0]     YEAR_SHIFT  = 15'd4800;
    localparam logic [JDN_W:0]      JDN_OFFSET  = 24'd32045;
    // bit (month - 1) set for 31-day months, jan..dec
    localparam logic [11:0]         LONG_MONTHS = 12'b1010_1101_0101;
    localparam logic [MONTH_W-1:0]  FEBRUARY    = 4'd2;
    localparam logic [MONTH_W-1:0]  DECEMBER    = 4'd12;

    // floor(x / 100) = (x * 5243) >> 19 for x below 2**15
    localparam logic [RECIP100_W-1:0] RECIP_100 = 13'd5243;
    localparam int unsigned           SHIFT_100 = 19;
    // floor(x / 7) = (x * 9586981) >> 26 for x below 2**23
    localparam logic [RECIP7_W-1:0]   RECIP_7   = 24'd9586981;
    localparam int unsigned           SHIFT_7   = 26;

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        ORDER_EARLIER = 2'd0,
        ORDER_EQUAL   = 2'd1,
        ORDER_LATER   = 2'd2
    } order_t;

    // one date after classification, march-based month and shifted year
    typedef struct packed {
        logic              ok;
        logic [DAY_W-1:0]  day;
        logic [MM_W-1:0]   mm;
        logic [YY_W-1:0]   yy;
    } date_t;

    typedef struct packed {
        date_t a;
        date_t b;
        logic  sec_lt;
        logic  sec_gt;
    } entry_t;

    // days from march 1 to the start of the march-based month
    function automatic logic [SPAN_W-1:0] month_span(input logic [MM_W-1:0] mm);
        logic [SPAN_W-1:0] r;
        case (mm)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/gdnc_front.sv =====
// ----------------------------------------------------------------------------
// gdnc_front
// accepts date pairs, runs the range checks and forms the queue entry
// ----------------------------------------------------------------------------
module gdnc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [gdnc_pkg::IN_W-1:0]     s_axis_tdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output gdnc_pkg::entry_t              out_data
);

    localparam int unsigned PROD_W = gdnc_pkg::YEAR_W + gdnc_pkg::RECIP100_W;

    function automatic gdnc_pkg::date_t classify(
        input logic [gdnc_pkg::DAY_W-1:0]    d,
        input logic [gdnc_pkg::MONTH_W-1:0]  m,
        input logic [gdnc_pkg::YEAR_W-1:0]   y,
        input logic [gdnc_pkg::SECOND_W-1:0] s
    );
        logic [PROD_W-1:0]             prod;
        logic [7:0]                    q100;
        logic [gdnc_pkg::YEAR_W-1:0]   cent_base;
        logic                          cent;
        logic                          leap;
        logic                          mon_ok;
        logic [15:0]                   long_bits;
        logic [gdnc_pkg::MONTH_W-1:0]  idx;
        logic                          long_m;
        logic [gdnc_pkg::DAY_W-1:0]    len;
        logic                          before_mar;
        gdnc_pkg::date_t               r;
        prod      = PROD_W'(y) * PROD_W'(gdnc_pkg::RECIP_100);
        q100      = 8'(prod >> gdnc_pkg::SHIFT_100);
        cent_base = gdnc_pkg::YEAR_W'(q100) * gdnc_pkg::YEAR_W'(100);
        cent      = (y == cent_base);
        // gregorian rule: every 4th year, centuries only every 400th
        leap      = ((y[1:0] == 2'b00) && !cent) || (cent && (q100[1:0] == 2'b00));
        mon_ok    = (m != '0) && (m <= gdnc_pkg::DECEMBER);
        long_bits = {4'b0000, gdnc_pkg::LONG_MONTHS};
        idx       = m - 4'd1;
        long_m    = long_bits[idx];
        if (m == gdnc_pkg::FEBRUARY)
            len = leap ? 5'd29 : 5'd28;
        else
            len = long_m ? 5'd31 : 5'd30;
        r.ok = mon_ok && (y <= gdnc_pkg::MAX_YEAR) && (s <= gdnc_pkg::MAX_SECOND)
               && (d != '0) && (d <= len);
        // january and february count as months 10 and 11 of the year before
        before_mar = (m <= gdnc_pkg::FEBRUARY);
        r.day = d;
        r.mm  = before_mar ? (m + 4'd9) : (m - 4'd3);
        r.yy  = gdnc_pkg::YY_W'(y) + gdnc_pkg::YEAR_SHIFT - gdnc_pkg::YY_W'(before_mar);
        return r;
    endfunction

    logic [gdnc_pkg::SECOND_W-1:0] second_a;
    logic [gdnc_pkg::SECOND_W-1:0] second_b;
    logic                          accept;
    logic                          valid_reg;
    logic                          valid_next;
    gdnc_pkg::entry_t              entry_reg;
    gdnc_pkg::entry_t              entry_next;

    assign second_a = s_axis_tdata[39:23];
    assign second_b = s_axis_tdata[79:63];

    assign s_axis_tready = !valid_reg || out_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        entry_next.a      = classify(s_axis_tdata[4:0], s_axis_tdata[8:5],
                                     s_axis_tdata[22:9], second_a);
        entry_next.b      = classify(s_axis_tdata[44:40], s_axis_tdata[48:45],
                                     s_axis_tdata[62:49], second_b);
        entry_next.sec_lt = (second_a < second_b);
        entry_next.sec_gt = (second_a > second_b);
    end

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            entry_reg <= entry_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = entry_reg;

endmodule

// ===== design/gdnc_queue.sv =====
// ----------------------------------------------------------------------------
// gdnc_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gdnc_queue #(
    parameter int unsigned DEPTH = gdnc_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  gdnc_pkg::entry_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output gdnc_pkg::entry_t  out_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    gdnc_pkg::entry_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_data;
    end

    // fill level follows pushes and pops exactly
    `GDNC_ASSERT_NEXT(queue_count_tracks, clk, rst_n, 1'b1, count_reg == $past(count_reg) + CNT_W'($past(push)) - CNT_W'($past(pop)))

endmodule

// ===== design/gdnc_back.sv =====
// ----------------------------------------------------------------------------
// gdnc_back
// day number, weekday, difference and order pipeline with output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gdnc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  gdnc_pkg::entry_t              in_data,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [gdnc_pkg::OUT_W-1:0]    m_axis_tdata
);

    localparam int unsigned P100_W = gdnc_pkg::YY_W + gdnc_pkg::RECIP100_W;
    localparam int unsigned P7_W   = gdnc_pkg::JDN_W + gdnc_pkg::RECIP7_W;
    localparam int unsigned YY4_W  = gdnc_pkg::YY_W - 2;
    localparam int unsigned SUM_W  = gdnc_pkg::JDN_W + 1;

    typedef struct packed {
        logic                          ok;
        logic [gdnc_pkg::SPAN_W-1:0]   span;
        logic [gdnc_pkg::JDN_W-1:0]    p365;
        logic [YY4_W-1:0]              yy4;
        logic [gdnc_pkg::Q100_W-1:0]   q100;
    } part_t;

    function automatic part_t split(input gdnc_pkg::date_t dt);
        logic [P100_W-1:0] prod;
        part_t             r;
        prod   = P100_W'(dt.yy) * P100_W'(gdnc_pkg::RECIP_100);
        r.ok   = dt.ok;
        r.span = gdnc_pkg::SPAN_W'(dt.day) + gdnc_pkg::month_span(dt.mm);
        r.p365 = gdnc_pkg::JDN_W'(dt.yy) * gdnc_pkg::JDN_W'(365);
        r.yy4  = YY4_W'(dt.yy >> 2);
        r.q100 = gdnc_pkg::Q100_W'(prod >> gdnc_pkg::SHIFT_100);
        return r;
    endfunction

    function automatic logic [gdnc_pkg::JDN_W-1:0] assemble(input part_t p);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(p.span) + SUM_W'(p.p365) + SUM_W'(p.yy4) - SUM_W'(p.q100)
              + SUM_W'(p.q100 >> 2) - gdnc_pkg::JDN_OFFSET;
        return p.ok ? gdnc_pkg::JDN_W'(sum) : '0;
    endfunction

    logic enable;

    // stage 1: year products and quotients
    logic   v1_reg;
    part_t  pa1_reg;
    part_t  pb1_reg;
    logic   lt1_reg;
    logic   gt1_reg;

    // stage 2: day numbers
    logic                         v2_reg;
    logic                         va2_reg;
    logic                         vb2_reg;
    logic [gdnc_pkg::JDN_W-1:0]   ja2_reg;
    logic [gdnc_pkg::JDN_W-1:0]   jb2_reg;
    logic                         lt2_reg;
    logic                         gt2_reg;

    // stage 3: weekday quotient, difference, order
    logic                         v3_reg;
    logic                         va3_reg;
    logic                         vb3_reg;
    logic [gdnc_pkg::JDN_W-1:0]   ja3_reg;
    logic [gdnc_pkg::JDN_W-1:0]   jb3_reg;
    logic [gdnc_pkg::Q7_W-1:0]    q7_reg;
    logic [gdnc_pkg::Q7_W-1:0]    q7_next;
    logic [gdnc_pkg::DIFF_W-1:0]  diff_reg;
    logic [gdnc_pkg::DIFF_W-1:0]  diff_next;
    gdnc_pkg::order_t             order_reg;
    gdnc_pkg::order_t             order_next;
    logic [P7_W-1:0]              prod7;

    // output register
    logic                            vout_reg;
    logic                            va_out_reg;
    logic                            vb_out_reg;
    logic [gdnc_pkg::JDN_W-1:0]      ja_out_reg;
    logic [gdnc_pkg::JDN_W-1:0]      jb_out_reg;
    logic [gdnc_pkg::WEEKDAY_W-1:0]  wd_out_reg;
    logic [gdnc_pkg::WEEKDAY_W-1:0]  wd_next;
    logic [gdnc_pkg::DIFF_W-1:0]     diff_out_reg;
    gdnc_pkg::order_t                order_out_reg;

    assign enable   = !vout_reg || m_axis_tready;
    assign in_ready = enable;

    always_comb
    begin
        prod7   = P7_W'(ja2_reg) * P7_W'(gdnc_pkg::RECIP_7);
        q7_next = gdnc_pkg::Q7_W'(prod7 >> gdnc_pkg::SHIFT_7);
        diff_next  = '0;
        order_next = gdnc_pkg::ORDER_EQUAL;
        if (va2_reg && vb2_reg)
        begin
            diff_next = (ja2_reg >= jb2_reg) ? gdnc_pkg::DIFF_W'(ja2_reg - jb2_reg)
                                             : gdnc_pkg::DIFF_W'(jb2_reg - ja2_reg);
            if ((ja2_reg < jb2_reg) || ((ja2_reg == jb2_reg) && lt2_reg))
                order_next = gdnc_pkg::ORDER_EARLIER;
            else if ((ja2_reg > jb2_reg) || ((ja2_reg == jb2_reg) && gt2_reg))
                order_next = gdnc_pkg::ORDER_LATER;
        end
    end

    // remainder by 7: jdn minus 7 times quotient
    assign wd_next = gdnc_pkg::WEEKDAY_W'(ja3_reg
                     - gdnc_pkg::JDN_W'(q7_reg) * gdnc_pkg::JDN_W'(7));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else if (enable)
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            vout_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            pa1_reg       <= split(in_data.a);
            pb1_reg       <= split(in_data.b);
            lt1_reg       <= in_data.sec_lt;
            gt1_reg       <= in_data.sec_gt;

            va2_reg       <= pa1_reg.ok;
            vb2_reg       <= pb1_reg.ok;
            ja2_reg       <= assemble(pa1_reg);
            jb2_reg       <= assemble(pb1_reg);
            lt2_reg       <= lt1_reg;
            gt2_reg       <= gt1_reg;

            va3_reg       <= va2_reg;
            vb3_reg       <= vb2_reg;
            ja3_reg       <= ja2_reg;
            jb3_reg       <= jb2_reg;
            q7_reg        <= q7_next;
            diff_reg      <= diff_next;
            order_reg     <= order_next;

            va_out_reg    <= va3_reg;
            vb_out_reg    <= vb3_reg;
            ja_out_reg    <= ja3_reg;
            jb_out_reg    <= jb3_reg;
            wd_out_reg    <= wd_next;
            diff_out_reg  <= diff_reg;
            order_out_reg <= order_reg;
        end
    end

    assign m_axis_tvalid = vout_reg;
    assign m_axis_tdata  = {(gdnc_pkg::OUT_W - gdnc_pkg::OUT_FIELDS_W)'(0),
                            order_out_reg, diff_out_reg, jb_out_reg, wd_out_reg,
                            ja_out_reg, vb_out_reg, va_out_reg};

    // an invalid date never reports a distance or an order
    `GDNC_ASSERT_IMPLY(back_invalid_neutral, clk, rst_n, vout_reg && !(va_out_reg && vb_out_reg), diff_out_reg == '0 && order_out_reg == gdnc_pkg::ORDER_EQUAL)

    // equal order implies the same day
    `GDNC_ASSERT_IMPLY(back_equal_same_day, clk, rst_n, vout_reg && order_out_reg == gdnc_pkg::ORDER_EQUAL, diff_out_reg == '0)

endmodule

// ===== design/gregorian_day_number_compare_core.sv =====
// ----------------------------------------------------------------------------
// gregorian_day_number_compare_core
// date pair check, julian day numbers, weekday, day distance and time order
// ----------------------------------------------------------------------------
// throughput: one item per cycle while the result side accepts, set by the back
//   pipeline stages sharing one stall enable with their output register
// reset: asynchronous, active low; clears all valid flags and queue pointers,
//   input ready is high on the first cycle after release
module gregorian_day_number_compare_core #(
    parameter int unsigned QUEUE_DEPTH = gdnc_pkg::QUEUE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input item
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // day_a, month_a, year_a, second_a, day_b, month_b, year_b, second_b
    input  logic [gdnc_pkg::IN_W-1:0]   s_axis_tdata,
    // result item
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // valid_a, valid_b, day_number_a, weekday_a, day_number_b, day_diff,
    // order, zero pad
    output logic [gdnc_pkg::OUT_W-1:0]  m_axis_tdata
);

    // front to queue
    logic              fq_valid;
    logic              fq_ready;
    gdnc_pkg::entry_t  fq_data;

    // queue to back
    logic              qb_valid;
    logic              qb_ready;
    gdnc_pkg::entry_t  qb_data;

    // front: range checks, leap year rule, march-based month and year shift
    gdnc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .out_valid     (fq_valid),
        .out_ready     (fq_ready),
        .out_data      (fq_data)
    );

    // queue decouples front acceptance from back stalls
    gdnc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    // back: day number assembly, weekday by reciprocal, distance and order
    gdnc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (qb_valid),
        .in_ready      (qb_ready),
        .in_data       (qb_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench for gregorian_day_number_compare_core
// drives date pairs over the input stream with bursty timing, predicts each
// result from the calendar rules and checks every output item field by field
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ITEMS           = 550;
    localparam int unsigned HOLD_OFF_AFTER  = 40;
    localparam int unsigned HOLD_OFF_CYCLES = 96;
    localparam int unsigned DRAIN_CYCLES    = 20;
    localparam logic [15:0] SINK_PATTERN    = 16'b1011_0111_0010_1110;

    // one calendar date as packed on the input bus, day in the lowest bits
    typedef struct packed {
        logic [gdnc_pkg::SECOND_W-1:0] second;
        logic [gdnc_pkg::YEAR_W-1:0]   year;
        logic [gdnc_pkg::MONTH_W-1:0]  month;
        logic [gdnc_pkg::DAY_W-1:0]    day;
    } cal_date_t;

    // one result as packed on the output bus, valid_a in bit 0
    typedef struct packed {
        gdnc_pkg::order_t                order;
        logic [gdnc_pkg::DIFF_W-1:0]     day_diff;
        logic [gdnc_pkg::JDN_W-1:0]      day_number_b;
        logic [gdnc_pkg::WEEKDAY_W-1:0]  weekday_a;
        logic [gdnc_pkg::JDN_W-1:0]      day_number_a;
        logic                            valid_b;
        logic                            valid_a;
    } compare_result_t;

    class date_pair_scoreboard;
        compare_result_t expected_compares[$];
        int unsigned     accepted;
        int unsigned     checked;
        int unsigned     errors;
        int unsigned     both_valid;
        int unsigned     order_seen[3];

        static function bit leap_year(int unsigned y);
            return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        endfunction

        // month must be 1..12
        static function int unsigned days_in_month(int unsigned m, int unsigned y);
            if (m == gdnc_pkg::FEBRUARY)
                return leap_year(y) ? 29 : 28;
            return gdnc_pkg::LONG_MONTHS[m - 1] ? 31 : 30;
        endfunction

        static function bit date_good(cal_date_t dt);
            if (dt.month < 1 || dt.month > gdnc_pkg::DECEMBER ||
                dt.year > gdnc_pkg::MAX_YEAR ||
                dt.second > gdnc_pkg::MAX_SECOND || dt.day == 0)
                return 1'b0;
            return dt.day <= days_in_month(dt.month, dt.year);
        endfunction

        // integer gregorian formula, march-based year
        static function int unsigned julian_day(cal_date_t dt);
            int unsigned mon;
            int unsigned early;
            int unsigned yy;
            int unsigned mm;
            mon   = dt.month;
            early = (14 - mon) / 12;
            yy    = dt.year + 4800 - early;
            mm    = mon + 12 * early - 3;
            return dt.day + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100
                   + yy / 400 - 32045;
        endfunction

        function compare_result_t predict_compare(logic [gdnc_pkg::IN_W-1:0] data);
            cal_date_t       a;
            cal_date_t       b;
            compare_result_t r;
            int unsigned     ja;
            int unsigned     jb;
            a = data[39:0];
            b = data[79:40];
            r = '0;
            r.order   = gdnc_pkg::ORDER_EQUAL;
            r.valid_a = date_good(a);
            r.valid_b = date_good(b);
            ja = r.valid_a ? julian_day(a) : 0;
            jb = r.valid_b ? julian_day(b) : 0;
            r.day_number_a = gdnc_pkg::JDN_W'(ja);
            r.day_number_b = gdnc_pkg::JDN_W'(jb);
            r.weekday_a    = gdnc_pkg::WEEKDAY_W'(ja % 7);
            if (r.valid_a && r.valid_b)
            begin
                r.day_diff = gdnc_pkg::DIFF_W'((ja >= jb) ? ja - jb : jb - ja);
                if (ja < jb || (ja == jb && a.second < b.second))
                    r.order = gdnc_pkg::ORDER_EARLIER;
                else if (ja > jb || (ja == jb && a.second > b.second))
                    r.order = gdnc_pkg::ORDER_LATER;
            end
            return r;
        endfunction

        function void note_input(logic [gdnc_pkg::IN_W-1:0] data);
            compare_result_t r;
            r = predict_compare(data);
            expected_compares.push_back(r);
            accepted++;
            if (r.valid_a && r.valid_b)
                both_valid++;
            order_seen[r.order]++;
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(logic [gdnc_pkg::OUT_W-1:0] data);
            compare_result_t got;
            compare_result_t want;
            got = data[gdnc_pkg::OUT_FIELDS_W-1:0];
            if (expected_compares.size() == 0)
            begin
                errors++;
                $display("%0t: result item with no pair pending, expected none, actual %h",
                         $time, data);
                return;
            end
            want = expected_compares.pop_front();
            checked++;
            compare_field("valid_a", want.valid_a, got.valid_a);
            compare_field("valid_b", want.valid_b, got.valid_b);
            compare_field("day_number_a", want.day_number_a, got.day_number_a);
            compare_field("weekday_a", want.weekday_a, got.weekday_a);
            compare_field("day_number_b", want.day_number_b, got.day_number_b);
            compare_field("day_diff", want.day_diff, got.day_diff);
            compare_field("order", want.order, got.order);
        endfunction

        function int unsigned pending();
            return expected_compares.size();
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [gdnc_pkg::IN_W-1:0]     s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [gdnc_pkg::OUT_W-1:0]    m_axis_tdata;

    date_pair_scoreboard sb;

    gregorian_day_number_compare_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic cal_date_t mk(int unsigned d, int unsigned m, int unsigned y,
                                     int unsigned s);
        cal_date_t dt;
        dt.day    = gdnc_pkg::DAY_W'(d);
        dt.month  = gdnc_pkg::MONTH_W'(m);
        dt.year   = gdnc_pkg::YEAR_W'(y);
        dt.second = gdnc_pkg::SECOND_W'(s);
        return dt;
    endfunction

    // every bit pattern the fields allow
    function automatic cal_date_t any_date();
        return mk($urandom_range(0, 31), $urandom_range(0, 15),
                  $urandom_range(0, 16383), $urandom_range(0, 131071));
    endfunction

    // well-formed date, leaning on centuries and month ends
    function automatic cal_date_t valid_date();
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned s;
        y = ($urandom_range(0, 7) == 0) ? 100 * $urandom_range(0, 99)
                                        : $urandom_range(0, 9999);
        m = $urandom_range(1, 12);
        d = ($urandom_range(0, 5) == 0) ? date_pair_scoreboard::days_in_month(m, y)
            : $urandom_range(1, date_pair_scoreboard::days_in_month(m, y));
        case ($urandom_range(0, 9))
            0:       s = 0;
            1:       s = gdnc_pkg::MAX_SECOND;
            default: s = $urandom_range(0, 86399);
        endcase
        return mk(d, m, y, s);
    endfunction

    // a valid date pushed onto or just past one of its range limits
    function automatic cal_date_t edge_date();
        cal_date_t   dt;
        int unsigned len;
        dt  = valid_date();
        len = date_pair_scoreboard::days_in_month(dt.month, dt.year);
        case ($urandom_range(0, 8))
            0: dt.day = gdnc_pkg::DAY_W'(len + 1);
            1: dt.day = '0;
            2: dt.second = gdnc_pkg::SECOND_W'($urandom_range(86400, 131071));
            3: dt.year = gdnc_pkg::YEAR_W'($urandom_range(10000, 16383));
            4: dt.month = '0;
            5: dt.month = gdnc_pkg::MONTH_W'($urandom_range(13, 15));
            6: dt = mk(29, 2, $urandom_range(0, 9999), dt.second);
            7: dt = mk(29, 2, 100 * $urandom_range(0, 99), dt.second);
            default: dt.day = gdnc_pkg::DAY_W'(len);
        endcase
        return dt;
    endfunction

    // hold the item until the core takes it; valid stays high for a follow-on item
    task automatic offer_pair(input cal_date_t a, input cal_date_t b);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic sender_gap(input int unsigned cycles);
        if (cycles == 0)
            return;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic offer_random_pair();
        cal_date_t   a;
        cal_date_t   b;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            a = valid_date();
            b = valid_date();
        end
        else if (pick < 72)
        begin
            // same calendar day, order decided by the second of day
            a = valid_date();
            b = a;
            if ($urandom_range(0, 2) != 0)
                b.second = gdnc_pkg::SECOND_W'($urandom_range(0, 86399));
        end
        else if (pick < 82)
        begin
            a = valid_date();
            b = edge_date();
            if ($urandom_range(0, 1) != 0)
                {a, b} = {b, a};
        end
        else if (pick < 92)
        begin
            a = edge_date();
            b = edge_date();
        end
        else
        begin
            a = any_date();
            b = any_date();
        end
        offer_pair(a, b);
    endtask

    // sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // result side: one long hold-off early on, then rotating stall patterns
    initial
    begin : result_sink
        int unsigned cyc;
        int unsigned mode;
        bit          held;
        cyc  = 0;
        held = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && sb.accepted >= HOLD_OFF_AFTER)
            begin
                // keep ready low long enough for the core to back up its input
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
                held = 1'b1;
            end
            else
            begin
                mode = (cyc / 32) % 4;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= SINK_PATTERN[cyc % 16];
                endcase
            end
            cyc++;
        end
    end

    initial
    begin : stimulus
        int unsigned sent;
        int unsigned burst;
        sb = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // range limits, leap rules, bad fields and the three orders
        offer_pair(mk(1, 1, 0, 0), mk(1, 1, 0, 0));
        offer_pair(mk(31, 12, 9999, 86399), mk(1, 1, 0, 0));
        offer_pair(mk(1, 1, 0, 0), mk(31, 12, 9999, 86399));
        offer_pair(mk(29, 2, 2000, 100), mk(29, 2, 1900, 100));
        offer_pair(mk(29, 2, 2024, 0), mk(28, 2, 2023, 0));
        offer_pair(mk(29, 2, 2023, 0), mk(29, 2, 0, 0));
        offer_pair(mk(15, 6, 1990, 86399), mk(15, 6, 1990, 86400));
        offer_pair(mk(15, 6, 1990, 131071), mk(16, 6, 1990, 0));
        offer_pair(mk(10, 0, 2001, 5), mk(10, 13, 2001, 5));
        offer_pair(mk(10, 15, 2001, 5), mk(10, 12, 2001, 5));
        offer_pair(mk(0, 3, 1500, 7), mk(31, 3, 1500, 7));
        offer_pair(mk(30, 4, 1776, 7), mk(31, 4, 1776, 7));
        offer_pair(mk(31, 7, 3000, 0), mk(31, 9, 3000, 0));
        offer_pair(mk(1, 1, 10000, 0), mk(1, 1, 9999, 0));
        offer_pair(mk(31, 12, 16383, 86399), mk(31, 12, 9999, 0));
        offer_pair(mk(4, 7, 1976, 100), mk(4, 7, 1976, 200));
        offer_pair(mk(4, 7, 1976, 200), mk(4, 7, 1976, 100));
        offer_pair(mk(4, 7, 1976, 300), mk(4, 7, 1976, 300));
        offer_pair(mk(1, 3, 2100, 0), mk(28, 2, 2100, 86399));
        offer_pair(mk(1, 3, 2400, 0), mk(29, 2, 2400, 86399));
        offer_pair(mk(31, 1, 2022, 0), mk(1, 2, 2022, 0));
        offer_pair(mk(31, 15, 16383, 131071), mk(31, 15, 16383, 131071));
        offer_pair(mk(0, 0, 0, 0), mk(0, 0, 0, 0));
        sent = 23;
        sender_gap(3);

        while (sent < ITEMS)
        begin
            burst = $urandom_range(1, 16);
            repeat (burst)
            begin
                offer_random_pair();
                sent++;
            end
            // some bursts run straight into the next one
            if ($urandom_range(0, 3) != 0)
                sender_gap($urandom_range(1, 6));
        end
        sender_gap(1);

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display(
            "covered %0d date pairs, %0d both valid, earlier/equal/later %0d/%0d/%0d",
            sb.accepted, sb.both_valid, sb.order_seen[gdnc_pkg::ORDER_EARLIER],
            sb.order_seen[gdnc_pkg::ORDER_EQUAL], sb.order_seen[gdnc_pkg::ORDER_LATER]);
        $display("%0d results checked, %0d mismatches, %0d still pending",
                 sb.checked, sb.errors, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // guard against a hung handshake
    initial
    begin : run_limit
        #2_000_000;
        $display("%0t: run limit reached", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
